// ===== hw/rtl/diff_drive_odometry_error_tracker_core_macros.svh =====
// ----------------------------------------------------------------------------
// Odometry tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_ERROR_TRACKER_CORE_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_ERROR_TRACKER_CORE_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ODT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true out of reset.
`define ODT_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/odt_pkg.sv =====
// ----------------------------------------------------------------------------
// Odometry tracker package
// Shared constants, types and arithmetic helpers.
// ----------------------------------------------------------------------------
package odt_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_NUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_DEN = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_WHEEL,
        ST_ERR,
        ST_INTEG,
        ST_HOLD
    } odt_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } odt_md_state_t;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_WHEEL,
        STEP_ERR,
        STEP_INTEG
    } odt_step_t;

    typedef struct packed {
        logic signed [31:0] dist_res;
        logic signed [31:0] angle;
        logic signed [31:0] dist_error;
        logic signed [31:0] angle_error;
        logic signed [31:0] dist_integral;
        logic signed [31:0] angle_integral;
        logic signed [31:0] dist_velocity;
        logic signed [31:0] angle_velocity;
        logic signed [31:0] dist_accel;
        logic signed [31:0] angle_accel;
    } odt_result_t;

    // Half of a sum or difference, truncated toward zero.
    function automatic logic signed [31:0] half_trunc(input logic signed [32:0] s);
        logic signed [32:0] t;
        t = s;
        if (t < 0)
        begin
            t = t + 33'sd1;
        end
        return 32'(t >>> 1);
    endfunction

    // v*15/16 truncated toward zero.
    function automatic logic signed [31:0] leak15(input logic signed [31:0] v);
        logic signed [36:0] x;
        x = (37'(v) <<< 4) - 37'(v);
        if (x < 0)
        begin
            x = x + 37'sd15;
        end
        return 32'(x >>> 4);
    endfunction

    // v*255/256 truncated toward zero.
    function automatic logic signed [31:0] leak255(input logic signed [31:0] v);
        logic signed [39:0] x;
        x = (40'(v) <<< 8) - 40'(v);
        if (x < 0)
        begin
            x = x + 40'sd255;
        end
        return 32'(x >>> 8);
    endfunction

endpackage

// ===== hw/rtl/odt_muldiv.sv =====
// ----------------------------------------------------------------------------
// Odometry tracker right-wheel scaler
// Bit-serial signed multiply by the numerator, then restoring divide.
// ----------------------------------------------------------------------------
`include "diff_drive_odometry_error_tracker_core_macros.svh"

module odt_muldiv (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] count,
    input  logic [15:0]        num,
    input  logic [15:0]        den,
    output logic               done,
    output logic signed [31:0] quot
);

    odt_pkg::odt_md_state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [48:0] work_reg, work_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] mag_reg, mag_next;
    logic [15:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic signed [31:0] quot_reg, quot_next;

    logic [32:0] upper_sum;
    logic [16:0] trial;
    logic        ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= odt_pkg::MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        mag_reg  <= mag_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        mag_next   = mag_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        quot_next  = quot_reg;
        upper_sum  = work_reg[48:16] + (work_reg[0] ? {1'b0, mag_reg} : 33'd0);
        trial      = {rem_reg, work_reg[47]};
        ge         = trial >= {1'b0, den_reg};
        unique case (state_reg)
            odt_pkg::MD_IDLE:
            begin
                if (start)
                begin
                    neg_next   = count[31];
                    mag_next   = count[31] ? 32'(-count) : 32'(count);
                    den_next   = (den == 16'd0) ? 16'd1 : den;
                    work_next  = {33'd0, num};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = odt_pkg::MD_MUL;
                end
            end
            odt_pkg::MD_MUL:
            begin
                work_next = 49'({upper_sum, work_reg[15:0]} >> 1);
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15)
                begin
                    cnt_next   = '0;
                    state_next = odt_pkg::MD_DIV;
                end
            end
            odt_pkg::MD_DIV:
            begin
                rem_next  = ge ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
                work_next = {1'b0, work_reg[46:0], ge};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                begin
                    quot_next  = neg_reg ? -$signed({work_reg[30:0], ge})
                                         : $signed({work_reg[30:0], ge});
                    done_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = odt_pkg::MD_IDLE;
                end
            end
            default:
            begin
                state_next = odt_pkg::MD_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign quot = quot_reg;

    `ODT_ASSERT(a_done_after_div, done |-> $past(state_reg) == odt_pkg::MD_DIV,
                "scaler finished without a divide pass")
    `ODT_ASSERT(a_mul_len, $fell(state_reg == odt_pkg::MD_MUL) |-> $past(cnt_reg) == 6'd15,
                "multiply pass left early")
    `ODT_ASSERT(a_rem_bound, state_reg == odt_pkg::MD_DIV |-> rem_reg < den_reg,
                "divide remainder out of range")

endmodule

// ===== hw/rtl/odt_track.sv =====
// ----------------------------------------------------------------------------
// Odometry tracker state update
// Wheel kinematics, target holding, errors and leaky integrals in three steps.
// ----------------------------------------------------------------------------
module odt_track (
    input  logic                 clk,
    input  logic                 rst_n,
    input  odt_pkg::odt_step_t   step,
    input  logic signed [31:0]   lpos,
    input  logic signed [31:0]   rpos,
    input  logic signed [31:0]   tdist,
    input  logic signed [31:0]   tangle,
    output odt_pkg::odt_result_t result
);

    logic signed [31:0] lprev_reg, lvel_reg, lacc_reg;
    logic signed [31:0] rprev_reg, rvel_reg, racc_reg;
    logic signed [31:0] idist_reg, iangle_reg;
    logic signed [31:0] hdist_reg, hangle_reg;
    logic               clr_d_reg, clr_a_reg;
    odt_pkg::odt_result_t res_reg;

    logic signed [31:0] ldv, rdv, id_base, ia_base, id_new, ia_new;

    always_comb
    begin
        ldv     = lpos - lprev_reg;
        rdv     = rpos - rprev_reg;
        id_base = clr_d_reg ? 32'sd0 : idist_reg;
        ia_base = clr_a_reg ? 32'sd0 : iangle_reg;
        if ((id_base < 0 && res_reg.dist_error > 0) || (id_base > 0 && res_reg.dist_error < 0))
        begin
            id_new = '0;
        end
        else
        begin
            id_new = res_reg.dist_error + odt_pkg::leak255(id_base);
        end
        if ((ia_base < 0 && res_reg.angle_error > 0) ||
            (ia_base > 0 && res_reg.angle_error < 0))
        begin
            ia_new = '0;
        end
        else
        begin
            ia_new = res_reg.angle_error + odt_pkg::leak255(ia_base);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lprev_reg  <= '0;
            lvel_reg   <= '0;
            lacc_reg   <= '0;
            rprev_reg  <= '0;
            rvel_reg   <= '0;
            racc_reg   <= '0;
            idist_reg  <= '0;
            iangle_reg <= '0;
            hdist_reg  <= '0;
            hangle_reg <= '0;
            clr_d_reg  <= 1'b0;
            clr_a_reg  <= 1'b0;
        end
        else
        begin
            unique case (step)
                odt_pkg::STEP_WHEEL:
                begin
                    lprev_reg  <= lpos;
                    lacc_reg   <= (ldv <<< 4) - lvel_reg;
                    lvel_reg   <= ldv + odt_pkg::leak15(lvel_reg);
                    rprev_reg  <= rpos;
                    racc_reg   <= (rdv <<< 4) - rvel_reg;
                    rvel_reg   <= rdv + odt_pkg::leak15(rvel_reg);
                    clr_d_reg  <= tdist != hdist_reg;
                    clr_a_reg  <= tangle != hangle_reg;
                    hdist_reg  <= tdist;
                    hangle_reg <= tangle;
                end
                odt_pkg::STEP_INTEG:
                begin
                    idist_reg  <= id_new;
                    iangle_reg <= ia_new;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (step)
            odt_pkg::STEP_WHEEL:
            begin
                res_reg.dist_res <= odt_pkg::half_trunc(33'(lpos) + 33'(rpos));
                res_reg.angle    <= odt_pkg::half_trunc(33'(lpos) - 33'(rpos));
            end
            odt_pkg::STEP_ERR:
            begin
                res_reg.dist_error     <= tdist - res_reg.dist_res;
                res_reg.angle_error    <= tangle - res_reg.angle;
                res_reg.dist_velocity  <= odt_pkg::half_trunc(33'(lvel_reg) + 33'(rvel_reg));
                res_reg.angle_velocity <= odt_pkg::half_trunc(33'(lvel_reg) - 33'(rvel_reg));
                res_reg.dist_accel     <= odt_pkg::half_trunc(33'(lacc_reg) + 33'(racc_reg));
                res_reg.angle_accel    <= odt_pkg::half_trunc(33'(lacc_reg) - 33'(racc_reg));
            end
            odt_pkg::STEP_INTEG:
            begin
                res_reg.dist_integral  <= id_new;
                res_reg.angle_integral <= ia_new;
            end
            default:
            begin
            end
        endcase
    end

    assign result = res_reg;

endmodule

// ===== hw/rtl/diff_drive_odometry_error_tracker_core.sv =====
// ----------------------------------------------------------------------------
// Differential-drive odometry and error tracker
// One result beat per input beat: positions, errors, integrals, rates.
// ----------------------------------------------------------------------------
// An input beat goes through these steps from acceptance until its result is
// loaded into the output register: the scaler is started, runs a bit-serial
// multiply of the right count by the numerator and then a restoring divide
// by the denominator, hands its quotient off, and three update steps follow
// (wheels, errors, integrals). A new beat is taken once the previous result
// is in the output register, even while that result still waits to be
// taken.
`include "diff_drive_odometry_error_tracker_core_macros.svh"

module diff_drive_odometry_error_tracker_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [odt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [31:0]              left_count,
    input  logic signed [31:0]              right_count,
    input  logic signed [31:0]              target_dist,
    input  logic signed [31:0]              target_angle,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [31:0]              dist_res,
    output logic signed [31:0]              angle,
    output logic signed [31:0]              dist_error,
    output logic signed [31:0]              angle_error,
    output logic signed [31:0]              dist_integral,
    output logic signed [31:0]              angle_integral,
    output logic signed [31:0]              dist_velocity,
    output logic signed [31:0]              angle_velocity,
    output logic signed [31:0]              dist_accel,
    output logic signed [31:0]              angle_accel
);

    odt_pkg::odt_state_t state_reg, state_next;
    logic [15:0]         num_reg, den_reg;
    logic signed [31:0]  lc_reg, rc_reg, td_reg, ta_reg, rpos_reg;
    logic                out_valid_reg, out_valid_next;
    odt_pkg::odt_result_t out_reg;
    odt_pkg::odt_result_t trk_res;
    odt_pkg::odt_step_t  step;
    logic                md_start, md_done, accept, load_out;
    logic signed [31:0]  md_quot;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= 16'd1;
            den_reg <= 16'd1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == odt_pkg::REG_SCALE_NUM)
            begin
                num_reg <= cfg_data;
            end
            else if (cfg_index == odt_pkg::REG_SCALE_DEN)
            begin
                den_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= odt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lc_reg <= 32'(signed'(left_count[odt_pkg::COUNT_WIDTH-1:0]));
            rc_reg <= 32'(signed'(right_count[odt_pkg::COUNT_WIDTH-1:0]));
            td_reg <= target_dist;
            ta_reg <= target_angle;
        end
        if (md_done)
        begin
            rpos_reg <= md_quot;
        end
        if (load_out)
        begin
            out_reg <= trk_res;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        md_start       = 1'b0;
        step           = odt_pkg::STEP_NONE;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            odt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = odt_pkg::ST_SCALE;
                end
            end
            odt_pkg::ST_SCALE:
            begin
                md_start = 1'b1;
                if (md_done)
                begin
                    state_next = odt_pkg::ST_WHEEL;
                end
            end
            odt_pkg::ST_WHEEL:
            begin
                step       = odt_pkg::STEP_WHEEL;
                state_next = odt_pkg::ST_ERR;
            end
            odt_pkg::ST_ERR:
            begin
                step       = odt_pkg::STEP_ERR;
                state_next = odt_pkg::ST_INTEG;
            end
            odt_pkg::ST_INTEG:
            begin
                step       = odt_pkg::STEP_INTEG;
                state_next = odt_pkg::ST_HOLD;
            end
            odt_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = odt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = odt_pkg::ST_IDLE;
            end
        endcase
    end

    // The scaler ignores start while busy, so holding it through ST_SCALE is safe.
    odt_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start && !md_done),
        .count (rc_reg),
        .num   (num_reg),
        .den   (den_reg),
        .done  (md_done),
        .quot  (md_quot)
    );

    odt_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .lpos   (lc_reg),
        .rpos   (rpos_reg),
        .tdist  (td_reg),
        .tangle (ta_reg),
        .result (trk_res)
    );

    assign out_valid      = out_valid_reg;
    assign dist_res       = out_reg.dist_res;
    assign angle          = out_reg.angle;
    assign dist_error     = out_reg.dist_error;
    assign angle_error    = out_reg.angle_error;
    assign dist_integral  = out_reg.dist_integral;
    assign angle_integral = out_reg.angle_integral;
    assign dist_velocity  = out_reg.dist_velocity;
    assign angle_velocity = out_reg.angle_velocity;
    assign dist_accel     = out_reg.dist_accel;
    assign angle_accel    = out_reg.angle_accel;

    `ODT_ASSERT(a_done_in_scale, md_done |-> state_reg == odt_pkg::ST_SCALE,
                "scaler result arrived outside the scale phase")
    `ODT_ASSERT(a_load_from_hold, load_out |-> state_reg == odt_pkg::ST_HOLD,
                "output loaded outside the hold phase")
    `ODT_ASSERT(a_hold_fills, state_reg == odt_pkg::ST_HOLD && !out_valid_reg |=> out_valid_reg,
                "free output register not filled from hold")
    `ODT_ASSERT_NEVER(a_no_drop, load_out && out_valid_reg && !out_ready,
                      "result overwritten before it was taken")

endmodule
